[sv/slpm_pkg.sv]
// Shared types and constants of the sidelink subframe pool marker.
package slpm_pkg;

   localparam int SF_W      = 14;
   localparam int BM_W      = 20;
   localparam int CSR_W     = 20;
   localparam int REG_IDX_W = 2;

   typedef logic [SF_W-1:0]      sf_type;
   typedef logic [BM_W-1:0]      bm_type;
   typedef logic [CSR_W-1:0]     csr_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_SYNC_PERIODIC   = 2'd0;
   localparam reg_idx_type REG_SYNC_OFFSET     = 2'd1;
   localparam reg_idx_type REG_SYNC_PERIOD     = 2'd2;
   localparam reg_idx_type REG_SUBFRAME_BITMAP = 2'd3;

   localparam logic   RST_SYNC_PERIODIC   = 1'b1;
   localparam sf_type RST_SYNC_OFFSET     = 14'd0;
   localparam sf_type RST_SYNC_PERIOD     = 14'd160;
   localparam bm_type RST_SUBFRAME_BITMAP = 20'd4;

   typedef struct packed {
      logic busy;
      logic load;
   } tot_ctl_type;

endpackage

[sv/slpm_if.sv]
// Valid/ready channels of the pool marker: tick requests and result words.
interface slpm_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface slpm_rsp_if;
   logic                 valid;
   logic                 ready;
   slpm_pkg::sf_type     subframe_number;
   logic                 is_sync;
   logic                 is_reserved;
   logic                 in_pool;
   slpm_pkg::sf_type     pool_index;
   logic                 period_end;

   modport source (output valid, output subframe_number, output is_sync,
                   output is_reserved, output in_pool, output pool_index,
                   output period_end, input ready);
   modport sink (input valid, input subframe_number, input is_sync,
                 input is_reserved, input in_pool, input pool_index,
                 input period_end, output ready);
endinterface

[sv/sidelink_subframe_pool_marker.sv]
// Top level of the sidelink subframe pool marker.
// Each request word on req_bus is one subframe tick; restart set in the word
// starts the walk at subframe zero before that tick. Each accepted tick yields
// exactly one result word on rsp_bus: subframe number, sync / reserved / pool
// flags, pool index and an end-of-period flag.
// The result word sits in the output register on the cycle after acceptance.
// Throughput is one tick per cycle while the totals are idle; the output
// register is refilled in the same cycle it is drained, so with the totals
// idle req_bus.ready stays high while rsp_bus.ready is high. When the receiver
// stalls, the output word holds and req_bus.ready drops until it is taken.
// The csr_ port writes the four registers. After reset and after every csr
// write, the non-sync and reserved counts are rederived: a one-bit-per-cycle
// divider gives the sync count, a reciprocal multiply the reserved count.
// While this runs, req_bus.ready is low. Reset clears the walk to subframe
// zero and loads the register defaults.
module sidelink_subframe_pool_marker #(
   parameter int FRAME_SUBFRAMES = 10240,
   parameter int BITMAP_LEN      = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  slpm_pkg::reg_idx_type csr_index,
   input  slpm_pkg::csr_type     csr_wdata,
   slpm_req_if.sink              req_bus,
   slpm_rsp_if.source            rsp_bus
);

   localparam int CNT_W = $clog2(FRAME_SUBFRAMES + 1);
   localparam int N_W   = $clog2(BITMAP_LEN);

   logic                  sync_periodic_ff;
   slpm_pkg::sf_type      sync_offset_ff;
   slpm_pkg::sf_type      sync_period_ff;
   slpm_pkg::bm_type      subframe_bitmap_ff;
   logic                  derive_ff;
   logic [CNT_W-1:0]      nonsync_total;
   logic [N_W-1:0]        reserved_total;
   slpm_pkg::tot_ctl_type tot_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_periodic_ff   <= slpm_pkg::RST_SYNC_PERIODIC;
         sync_offset_ff     <= slpm_pkg::RST_SYNC_OFFSET;
         sync_period_ff     <= slpm_pkg::RST_SYNC_PERIOD;
         subframe_bitmap_ff <= slpm_pkg::RST_SUBFRAME_BITMAP;
         derive_ff          <= 1'b1;
      end else begin
         derive_ff <= csr_we;
         if (csr_we) begin
            case (csr_index)
               slpm_pkg::REG_SYNC_PERIODIC: begin
                  sync_periodic_ff <= csr_wdata[0];
               end
               slpm_pkg::REG_SYNC_OFFSET: begin
                  sync_offset_ff <= csr_wdata[slpm_pkg::SF_W-1:0];
               end
               slpm_pkg::REG_SYNC_PERIOD: begin
                  sync_period_ff <= csr_wdata[slpm_pkg::SF_W-1:0];
               end
               slpm_pkg::REG_SUBFRAME_BITMAP: begin
                  subframe_bitmap_ff <= csr_wdata[slpm_pkg::BM_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   slpm_totals #(
      .FRAME_SUBFRAMES (FRAME_SUBFRAMES),
      .BITMAP_LEN      (BITMAP_LEN)
   ) u_totals (
      .clock          (clock),
      .reset          (reset),
      .start          (derive_ff),
      .sync_periodic  (sync_periodic_ff),
      .sync_offset    (sync_offset_ff),
      .sync_period    (sync_period_ff),
      .nonsync_total  (nonsync_total),
      .reserved_total (reserved_total),
      .ctl            (tot_ctl)
   );

   slpm_walk #(
      .FRAME_SUBFRAMES (FRAME_SUBFRAMES),
      .BITMAP_LEN      (BITMAP_LEN)
   ) u_walk (
      .clock           (clock),
      .reset           (reset),
      .sync_periodic   (sync_periodic_ff),
      .sync_offset     (sync_offset_ff),
      .sync_period     (sync_period_ff),
      .subframe_bitmap (subframe_bitmap_ff),
      .nonsync_total   (nonsync_total),
      .reserved_total  (reserved_total),
      .ctl             (tot_ctl),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus)
   );

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      tot_ctl.busy |-> !req_bus.ready)
      else $error("tick accepted while totals are being derived");

   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_bus.ready)
      else $error("ready high right after a register write");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> $onehot0({rsp_bus.is_sync, rsp_bus.is_reserved, rsp_bus.in_pool}))
      else $error("sync, reserved and pool flags overlap");

   a_pend_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.period_end) |->
         (rsp_bus.subframe_number == slpm_pkg::sf_type'(FRAME_SUBFRAMES - 1)))
      else $error("period end flagged on a subframe other than the last");

endmodule

[sv/slpm_div.sv]
// Restoring divider, one quotient bit per cycle.
module slpm_div #(
   parameter int W = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   typedef logic [W-1:0]  w_type;
   typedef logic [W:0]    trial_type;
   typedef logic [CW-1:0] c_type;

   w_type     quo_ff, quo_in;
   w_type     rem_ff, rem_in;
   w_type     dsr_ff, dsr_in;
   c_type     cnt_ff, cnt_in;
   logic      done_ff, done_in;
   trial_type trial;
   trial_type diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = c_type'(W);
      end else if (cnt_ff != '0) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - c_type'(1);
         done_in = (cnt_ff == c_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/slpm_totals.sv]
// Derives the non-sync subframe count and the reserved count from the registers.
module slpm_totals #(
   parameter int FRAME_SUBFRAMES = 10240,
   parameter int BITMAP_LEN      = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   sync_periodic,
   input  slpm_pkg::sf_type                       sync_offset,
   input  slpm_pkg::sf_type                       sync_period,
   output logic [$clog2(FRAME_SUBFRAMES+1)-1:0]   nonsync_total,
   output logic [$clog2(BITMAP_LEN)-1:0]          reserved_total,
   output slpm_pkg::tot_ctl_type                  ctl
);

   localparam int CNT_W  = $clog2(FRAME_SUBFRAMES + 1);
   localparam int DW     = (CNT_W > slpm_pkg::SF_W) ? CNT_W : slpm_pkg::SF_W;
   localparam int N_W    = $clog2(BITMAP_LEN);
   localparam int RCP_SH = CNT_W + N_W;
   localparam int RCP_W  = CNT_W + 1;
   localparam int PROD_W = CNT_W + RCP_W;

   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DW-1:0]     dw_type;
   typedef logic [N_W-1:0]    n_type;
   typedef logic [RCP_W-1:0]  rcp_type;
   typedef logic [PROD_W-1:0] prod_type;

   // ceil(2^RCP_SH / BITMAP_LEN): exact quotient for every count below 2^CNT_W
   localparam rcp_type RCP = rcp_type'((2 ** RCP_SH + BITMAP_LEN - 1) / BITMAP_LEN);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CHECK    = 3'd1;
   localparam logic [2:0] S_DIV_SYNC = 3'd2;
   localparam logic [2:0] S_MOD_QUOT = 3'd3;
   localparam logic [2:0] S_MOD_REM  = 3'd4;
   localparam logic [2:0] S_LOAD     = 3'd5;

   logic [2:0] state_ff, state_in;
   cnt_type    l_ff, l_in;
   n_type      n_ff, n_in;
   cnt_type    q_ff, q_in;
   prod_type   prod;
   logic       div_start;
   dw_type     div_a, div_b;
   logic       div_done;
   dw_type     div_q;
   dw_type     frame_dw, off_dw, per_dw;

   slpm_div #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      frame_dw  = dw_type'(FRAME_SUBFRAMES);
      off_dw    = dw_type'(sync_offset);
      per_dw    = dw_type'(sync_period);
      prod      = prod_type'(l_ff) * prod_type'(RCP);
      state_in  = state_ff;
      l_in      = l_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      case (state_ff)
         S_IDLE: begin
            state_in = S_IDLE;
         end
         S_CHECK: begin
            if (off_dw >= frame_dw) begin
               l_in     = cnt_type'(FRAME_SUBFRAMES);
               state_in = S_MOD_QUOT;
            end else if (sync_periodic && per_dw != '0) begin
               div_start = 1'b1;
               div_a     = frame_dw - dw_type'(1) - off_dw;
               div_b     = per_dw;
               state_in  = S_DIV_SYNC;
            end else begin
               l_in     = cnt_type'(FRAME_SUBFRAMES - 1);
               state_in = S_MOD_QUOT;
            end
         end
         S_DIV_SYNC: begin
            if (div_done) begin
               l_in     = cnt_type'(frame_dw - dw_type'(1) - div_q);
               state_in = S_MOD_QUOT;
            end
         end
         S_MOD_QUOT: begin
            q_in     = cnt_type'(prod >> RCP_SH);
            state_in = S_MOD_REM;
         end
         S_MOD_REM: begin
            n_in     = n_type'(l_ff - q_ff * cnt_type'(BITMAP_LEN));
            state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (start) begin
         state_in = S_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      n_ff <= n_in;
      q_ff <= q_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign nonsync_total  = l_ff;
   assign reserved_total = n_ff;
   assign ctl.busy       = start || (state_ff != S_IDLE);
   assign ctl.load       = (state_ff == S_LOAD);

endmodule

[sv/slpm_walk.sv]
// Per-tick subframe walk: sync, reserved and pool marking into the result register.
module slpm_walk #(
   parameter int FRAME_SUBFRAMES = 10240,
   parameter int BITMAP_LEN      = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   sync_periodic,
   input  slpm_pkg::sf_type                       sync_offset,
   input  slpm_pkg::sf_type                       sync_period,
   input  slpm_pkg::bm_type                       subframe_bitmap,
   input  logic [$clog2(FRAME_SUBFRAMES+1)-1:0]   nonsync_total,
   input  logic [$clog2(BITMAP_LEN)-1:0]          reserved_total,
   input  slpm_pkg::tot_ctl_type                  ctl,
   slpm_req_if.sink                               req_bus,
   slpm_rsp_if.source                             rsp_bus
);

   localparam int CNT_W = $clog2(FRAME_SUBFRAMES + 1);
   localparam int DW    = (CNT_W > slpm_pkg::SF_W) ? CNT_W : slpm_pkg::SF_W;
   localparam int N_W   = $clog2(BITMAP_LEN);
   localparam int POS_W = $clog2(BITMAP_LEN);
   localparam int ACC_W = $clog2((FRAME_SUBFRAMES + 1) * BITMAP_LEN + 1);

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [DW-1:0]    dw_type;
   typedef logic [DW:0]      wide_type;
   typedef logic [N_W-1:0]   n_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [ACC_W-1:0] acc_type;

   cnt_type sf_ff, sf_in;
   cnt_type nsp_ff, nsp_in;
   cnt_type idx_ff, idx_in;
   n_type   done_ff, done_in;
   acc_type accr_ff, accr_in;
   acc_type acci_ff, acci_in;
   pos_type pos_ff, pos_in;
   cnt_type pool_ff, pool_in;

   logic             rsp_valid_ff, rsp_valid_in;
   slpm_pkg::sf_type rsp_sf_ff, rsp_sf_in;
   logic             rsp_sync_ff, rsp_sync_in;
   logic             rsp_resv_ff, rsp_resv_in;
   logic             rsp_pool_ff, rsp_pool_in;
   slpm_pkg::sf_type rsp_pidx_ff, rsp_pidx_in;
   logic             rsp_pend_ff, rsp_pend_in;

   logic             accept;
   cnt_type          off_sat;
   cnt_type          b_sf, b_nsp, b_idx, b_pool;
   n_type            b_done;
   acc_type          b_accr, b_acci;
   pos_type          b_pos;
   logic             sync, resv, pool_hit, pend;
   wide_type         nsp_sum;
   slpm_pkg::bm_type bm_shift;

   assign req_bus.ready = !ctl.busy && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      off_sat = (dw_type'(sync_offset) >= dw_type'(FRAME_SUBFRAMES))
              ? cnt_type'(FRAME_SUBFRAMES) : cnt_type'(sync_offset);

      // restart puts the walk back at subframe zero before this tick
      b_sf   = req_bus.restart ? '0 : sf_ff;
      b_nsp  = req_bus.restart ? off_sat : nsp_ff;
      b_idx  = req_bus.restart ? '0 : idx_ff;
      b_done = req_bus.restart ? '0 : done_ff;
      b_accr = req_bus.restart ? '0 : accr_ff;
      b_acci = req_bus.restart ? '0 : acci_ff;
      b_pos  = req_bus.restart ? '0 : pos_ff;
      b_pool = req_bus.restart ? '0 : pool_ff;

      nsp_sum = wide_type'(b_nsp) + wide_type'(sync_period);
      if (sync_periodic) begin
         sync = (b_sf == b_nsp) && (b_nsp < cnt_type'(FRAME_SUBFRAMES));
      end else begin
         sync = (dw_type'(b_sf) == dw_type'(sync_offset));
      end

      resv = !sync && (b_done < reserved_total) && (b_accr >= b_acci)
             && (b_accr < b_acci + acc_type'(reserved_total));

      bm_shift = subframe_bitmap >> b_pos;
      pool_hit = !sync && !resv && bm_shift[0];

      pend = (b_sf == cnt_type'(FRAME_SUBFRAMES - 1));

      sf_in   = b_sf + cnt_type'(1);
      nsp_in  = b_nsp;
      idx_in  = b_idx;
      done_in = b_done;
      accr_in = b_accr;
      acci_in = b_acci;
      pos_in  = b_pos;
      pool_in = b_pool;

      if (sync && sync_periodic) begin
         nsp_in = (nsp_sum > wide_type'(FRAME_SUBFRAMES))
                ? cnt_type'(FRAME_SUBFRAMES) : cnt_type'(nsp_sum);
      end
      if (!sync) begin
         if (resv) begin
            done_in = b_done + n_type'(1);
            accr_in = b_accr + acc_type'(nonsync_total);
         end else begin
            if (pool_hit) begin
               pool_in = b_pool + cnt_type'(1);
            end
            pos_in = (b_pos == pos_type'(BITMAP_LEN - 1)) ? '0 : b_pos + pos_type'(1);
         end
         idx_in  = b_idx + cnt_type'(1);
         acci_in = b_acci + acc_type'(reserved_total);
      end
      if (pend) begin
         sf_in   = '0;
         nsp_in  = off_sat;
         idx_in  = '0;
         done_in = '0;
         accr_in = '0;
         acci_in = '0;
         pos_in  = '0;
         pool_in = '0;
      end

      rsp_sf_in   = slpm_pkg::sf_type'(b_sf);
      rsp_sync_in = sync;
      rsp_resv_in = resv;
      rsp_pool_in = pool_hit;
      rsp_pidx_in = pool_hit ? slpm_pkg::sf_type'(b_pool) : '0;
      rsp_pend_in = pend;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff        <= '0;
         nsp_ff       <= cnt_type'(slpm_pkg::RST_SYNC_OFFSET);
         idx_ff       <= '0;
         done_ff      <= '0;
         accr_ff      <= '0;
         acci_ff      <= '0;
         pos_ff       <= '0;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            sf_ff   <= sf_in;
            nsp_ff  <= nsp_in;
            idx_ff  <= idx_in;
            done_ff <= done_in;
            accr_ff <= accr_in;
            acci_ff <= acci_in;
            pos_ff  <= pos_in;
            pool_ff <= pool_in;
         end else if (ctl.load) begin
            // products against the freshly derived totals
            accr_ff <= acc_type'(done_ff) * acc_type'(nonsync_total);
            acci_ff <= acc_type'(idx_ff) * acc_type'(reserved_total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sf_ff   <= rsp_sf_in;
         rsp_sync_ff <= rsp_sync_in;
         rsp_resv_ff <= rsp_resv_in;
         rsp_pool_ff <= rsp_pool_in;
         rsp_pidx_ff <= rsp_pidx_in;
         rsp_pend_ff <= rsp_pend_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.subframe_number = rsp_sf_ff;
   assign rsp_bus.is_sync         = rsp_sync_ff;
   assign rsp_bus.is_reserved     = rsp_resv_ff;
   assign rsp_bus.in_pool         = rsp_pool_ff;
   assign rsp_bus.pool_index      = rsp_pidx_ff;
   assign rsp_bus.period_end      = rsp_pend_ff;

endmodule

[verif/testbench.sv]
// Self-checking testbench of the sidelink subframe pool marker: directed settings, random walks.
module testbench;

   localparam int unsigned FRAME        = 10240;
   localparam int unsigned GROUP_LEN    = 20;
   localparam int unsigned CYCLE_CAP    = 600000;
   localparam int unsigned RANDOM_TICKS = 1330;

   typedef struct packed {
      slpm_pkg::sf_type subframe_number;
      logic             is_sync;
      logic             is_reserved;
      logic             in_pool;
      slpm_pkg::sf_type pool_index;
      logic             period_end;
   } tick_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   slpm_pkg::reg_idx_type csr_index;
   slpm_pkg::csr_type     csr_wdata;

   slpm_req_if req_bus ();
   slpm_rsp_if rsp_bus ();

   sidelink_subframe_pool_marker #(
      .FRAME_SUBFRAMES (FRAME),
      .BITMAP_LEN      (GROUP_LEN)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copies
   logic             cfg_periodic;
   slpm_pkg::sf_type cfg_offset;
   slpm_pkg::sf_type cfg_period;
   slpm_pkg::bm_type cfg_bitmap;

   // walk state
   int unsigned walk_sf;
   int unsigned next_sync_sf;
   int unsigned nonsync_seen;
   int unsigned reserved_marked;
   int unsigned reserved_goal;
   int unsigned seen_times_n;
   int unsigned group_pos;
   int unsigned pool_seen;
   int unsigned nonsync_per_period;
   int unsigned reserved_per_period;

   tick_word_type expected_ticks[$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   ticks_sent = 0;
   bit            quiet = 1'b0;
   bit            sender_idles = 1'b1;
   int unsigned   ready_hold = 0;

   function automatic void derive_pool_totals();
      int unsigned syncs;
      syncs = 0;
      if (cfg_offset < FRAME) begin
         if (cfg_periodic && cfg_period != 0)
            syncs = 1 + (FRAME - 1 - cfg_offset) / cfg_period;
         else
            syncs = 1;
      end
      nonsync_per_period  = FRAME - syncs;
      reserved_per_period = nonsync_per_period % GROUP_LEN;
   endfunction

   function automatic void restart_walk();
      walk_sf         = 0;
      next_sync_sf    = cfg_offset;
      nonsync_seen    = 0;
      reserved_marked = 0;
      reserved_goal   = 0;
      seen_times_n    = 0;
      group_pos       = 0;
      pool_seen       = 0;
   endfunction

   function automatic tick_word_type predict_tick(bit restart);
      tick_word_type w;
      int unsigned   sf;
      int unsigned   nx;
      int unsigned   pidx;
      w = '0;
      pidx = 0;
      if (restart)
         restart_walk();
      sf = walk_sf;
      if (cfg_periodic) begin
         if (sf == next_sync_sf && next_sync_sf < FRAME) begin
            nx = next_sync_sf + cfg_period;
            w.is_sync = 1'b1;
            next_sync_sf = (nx > FRAME) ? FRAME : nx;
         end
      end else if (sf == cfg_offset) begin
         w.is_sync = 1'b1;
      end
      if (!w.is_sync) begin
         reserved_goal = reserved_marked * nonsync_per_period;
         seen_times_n  = nonsync_seen * reserved_per_period;
         if (reserved_marked < reserved_per_period && reserved_goal >= seen_times_n &&
             reserved_goal < seen_times_n + reserved_per_period) begin
            w.is_reserved   = 1'b1;
            reserved_marked = (reserved_marked + 1) & 32'h7F;
         end else begin
            if (group_pos < 32 && ((32'(cfg_bitmap) >> group_pos) & 1)) begin
               w.in_pool = 1'b1;
               pidx      = pool_seen;
               pool_seen = (pool_seen + 1) & 32'h7FFF;
            end
            group_pos = (group_pos + 1 >= GROUP_LEN) ? 0 : group_pos + 1;
         end
         nonsync_seen = (nonsync_seen + 1) & 32'h7FFF;
      end
      w.period_end = (sf + 1 >= FRAME);
      if (w.period_end)
         restart_walk();
      else
         walk_sf = sf + 1;
      w.subframe_number = slpm_pkg::sf_type'(sf);
      w.pool_index      = slpm_pkg::sf_type'(pidx);
      return w;
   endfunction

   function automatic string word_text(tick_word_type w);
      return $sformatf("sf=%0d sync=%b resv=%b pool=%b idx=%0d end=%b", w.subframe_number,
                       w.is_sync, w.is_reserved, w.in_pool, w.pool_index, w.period_end);
   endfunction

   // result checker
   always @(posedge clock) begin
      tick_word_type got;
      tick_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.subframe_number, rsp_bus.is_sync, rsp_bus.is_reserved,
                 rsp_bus.in_pool, rsp_bus.pool_index, rsp_bus.period_end};
         if (expected_ticks.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result word: %s", word_text(got));
         end else begin
            want = expected_ticks.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %s, got %s", word_text(want), word_text(got));
            end
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_bus.ready <= 1'b1;
            ready_hold <= 0;
         end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
         end else if (rsp_bus.ready) begin
            if ($urandom_range(0, 3) == 0) begin
               rsp_bus.ready <= 1'b0;
               ready_hold <= $urandom_range(0, 17);
            end else begin
               ready_hold <= $urandom_range(0, 40);
            end
         end else begin
            rsp_bus.ready <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_tick(input bit restart);
      if (!quiet && sender_idles && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_ticks.insert(expected_ticks.size(), predict_tick(restart));
      ticks_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input slpm_pkg::reg_idx_type idx, input slpm_pkg::csr_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         slpm_pkg::REG_SYNC_PERIODIC:   cfg_periodic = value[0];
         slpm_pkg::REG_SYNC_OFFSET:     cfg_offset   = value[slpm_pkg::SF_W-1:0];
         slpm_pkg::REG_SYNC_PERIOD:     cfg_period   = value[slpm_pkg::SF_W-1:0];
         slpm_pkg::REG_SUBFRAME_BITMAP: cfg_bitmap   = value[slpm_pkg::BM_W-1:0];
         default: ;
      endcase
      derive_pool_totals();
      repeat (2) @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic apply_settings(input bit periodic, input slpm_pkg::sf_type offset,
                                 input slpm_pkg::sf_type period, input slpm_pkg::bm_type bitmap,
                                 input bit junk);
      slpm_pkg::csr_type hi;
      hi = junk ? slpm_pkg::csr_type'($urandom) : '0;
      wait_for_results();
      write_csr(slpm_pkg::REG_SYNC_PERIODIC, {hi[slpm_pkg::CSR_W-1:1], periodic});
      write_csr(slpm_pkg::REG_SYNC_OFFSET, {hi[slpm_pkg::CSR_W-1:slpm_pkg::SF_W], offset});
      write_csr(slpm_pkg::REG_SYNC_PERIOD, {hi[slpm_pkg::CSR_W-1:slpm_pkg::SF_W], period});
      write_csr(slpm_pkg::REG_SUBFRAME_BITMAP, slpm_pkg::csr_type'(bitmap));
   endtask

   task automatic random_settings();
      bit               periodic;
      slpm_pkg::sf_type offset;
      slpm_pkg::sf_type period;
      slpm_pkg::bm_type bitmap;
      periodic = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
         0: offset = '0;
         1: offset = slpm_pkg::sf_type'($urandom_range(0, 60));
         2: offset = slpm_pkg::sf_type'($urandom_range(0, FRAME - 1));
         3: offset = slpm_pkg::sf_type'($urandom_range(FRAME, 16383));
         default: offset = slpm_pkg::sf_type'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 4))
         0: period = slpm_pkg::sf_type'($urandom_range(0, 3));
         1: period = slpm_pkg::sf_type'($urandom_range(4, 40));
         2: period = slpm_pkg::sf_type'($urandom_range(41, 400));
         3: period = slpm_pkg::sf_type'($urandom_range(401, 16383));
         default: period = slpm_pkg::RST_SYNC_PERIOD;
      endcase
      case ($urandom_range(0, 4))
         0: bitmap = '1;
         1: bitmap = slpm_pkg::bm_type'(1) << $urandom_range(0, slpm_pkg::BM_W - 1);
         2: bitmap = '0;
         default: bitmap = slpm_pkg::bm_type'($urandom);
      endcase
      apply_settings(periodic, offset, period, bitmap, $urandom_range(0, 3) == 0);
   endtask

   task automatic test_defaults_after_reset();
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
   endtask

   // offset past the frame, single sync, zero period, every subframe sync, widest period
   task automatic test_special_settings();
      apply_settings(1'b1, slpm_pkg::sf_type'(16383), slpm_pkg::RST_SYNC_PERIOD, '1, 1'b0);
      repeat (3) send_tick(1'b0);
      apply_settings(1'b0, slpm_pkg::sf_type'(1), '0, '0, 1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      apply_settings(1'b1, '0, '0, slpm_pkg::bm_type'(20'h5_5555), 1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      apply_settings(1'b1, '0, slpm_pkg::sf_type'(1), slpm_pkg::bm_type'(20'hA_AAAA), 1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      apply_settings(1'b1, slpm_pkg::sf_type'(1), slpm_pkg::sf_type'(16383), '1, 1'b1);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
   endtask

   // settings change mid-period; restarts are rare so walks run deep
   task automatic test_random_ticks();
      int unsigned goal;
      int unsigned run;
      goal = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < goal) begin
         random_settings();
         sender_idles = ($urandom_range(0, 3) != 0);
         run = $urandom_range(120, 260);
         for (int unsigned i = 0; i < run && ticks_sent < goal; i++) begin
            if ($urandom_range(0, 149) == 0)
               wait_for_results();
            send_tick($urandom_range(0, 79) == 0);
         end
      end
      sender_idles = 1'b1;
   endtask

   // runs back to back with no idling: dense periodic sync, then a single sync
   task automatic test_quiet_runs();
      wait_for_results();
      quiet = 1'b1;
      apply_settings(1'b1, slpm_pkg::sf_type'(2), slpm_pkg::sf_type'(3),
                     slpm_pkg::bm_type'($urandom), 1'b0);
      send_tick(1'b1);
      repeat (100) send_tick(1'b0);
      apply_settings(1'b0, slpm_pkg::sf_type'(50), slpm_pkg::sf_type'(1), '1, 1'b0);
      send_tick(1'b1);
      repeat (100) send_tick(1'b0);
   endtask

   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= slpm_pkg::REG_SYNC_PERIODIC;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.restart <= 1'b0;
      cfg_periodic = slpm_pkg::RST_SYNC_PERIODIC;
      cfg_offset   = slpm_pkg::RST_SYNC_OFFSET;
      cfg_period   = slpm_pkg::RST_SYNC_PERIOD;
      cfg_bitmap   = slpm_pkg::RST_SUBFRAME_BITMAP;
      restart_walk();
      derive_pool_totals();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_after_reset();
      test_special_settings();
      test_random_ticks();
      test_quiet_runs();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
